// ----- rtl/four_digit_seven_segment_mux_defines.svh -----
// assertion macros for the seven-segment display driver checker
// expects clk and rst to be visible where a macro is used
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_MUX_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_MUX_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define FDSSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define FDSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fdssm_pkg.sv -----
// shared types, constants and segment decode for the display driver
// no dependencies
`default_nettype none

package fdssm_pkg;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned DIGIT_IDX_W = $clog2(DIGIT_COUNT);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DP_POSITION = 2'd2;

  localparam logic [15:0] SLOT_LENGTH_RST = 16'd4999;
  localparam logic [6:0]  BRIGHTNESS_RST  = 7'd100;
  localparam logic [1:0]  DP_POSITION_RST = 2'd3;
  localparam logic [6:0]  BRIGHTNESS_MIN  = 7'd5;
  localparam logic [6:0]  BRIGHTNESS_MAX  = 7'd100;

  localparam logic        MODE_TICK = 1'b0;
  localparam logic        MODE_LOAD = 1'b1;

  localparam logic [7:0]  SEG_RST     = 8'hFF;
  localparam logic [7:0]  SEG_DP      = 8'h20;
  localparam logic [3:0]  DIGIT_ERROR = 4'hE;
  localparam logic [15:0] VALUE_MAX   = 16'd9999;

  // floor division by reciprocal multiply, exact over the full input range
  localparam logic [16:0] RECIP_10      = 17'd104858;
  localparam int unsigned SHIFT_10      = 20;
  localparam logic [16:0] RECIP_100     = 17'd83887;
  localparam int unsigned SHIFT_100     = 23;
  localparam logic [16:0] RECIP_1000    = 17'd67109;
  localparam int unsigned SHIFT_1000    = 26;
  localparam logic [23:0] RECIP_PERCENT = 24'd10737419;
  localparam int unsigned SHIFT_PERCENT = 30;

  // cycles for the brightness compare pipeline to refill
  localparam logic [2:0]  SETTLE_CYCLES = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             segments;
    logic [DIGIT_COUNT-1:0] digit_enable;
    logic [DIGIT_IDX_W-1:0] active_index;
  } out_item_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] pat;
    unique case (code)
      4'h0: pat = 8'hD7;
      4'h1: pat = 8'h11;
      4'h2: pat = 8'h8F;
      4'h3: pat = 8'h9B;
      4'h4: pat = 8'h59;
      4'h5: pat = 8'hDA;
      4'h6: pat = 8'hDE;
      4'h7: pat = 8'h91;
      4'h8: pat = 8'hDF;
      4'h9: pat = 8'hDB;
      4'hA: pat = 8'hDD;
      4'hB: pat = 8'h5E;
      4'hC: pat = 8'hC6;
      4'hD: pat = 8'h1F;
      4'hE: pat = 8'hCE;
      4'hF: pat = 8'hCC;
      default: pat = 8'hCC;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/four_digit_seven_segment_mux.sv -----
// four-digit multiplexed seven-segment display driver
// an item passes through s1, s2 and the output register; throughput one item per cycle
// while nothing stalls; the brightness compare comes from a 4-stage multiply pipeline;
// after reset and after each config write the input stalls while it refills
// reset: counter 0, digit 0 selected and lit, all segments on, digits zero,
// slot length 4999, brightness 100 percent, decimal point position 3
`default_nettype none

module four_digit_seven_segment_mux (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire fdssm_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output fdssm_pkg::out_item_t                     out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fdssm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fdssm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration
  logic [15:0] slot_length;
  logic [6:0]  brightness;
  logic [1:0]  dp_position;
  logic        cfg_write;

  // compare pipeline
  logic [16:0] slot_ticks;
  logic [6:0]  percent;
  logic [23:0] on_product;
  logic [47:0] percent_mul;
  logic [15:0] on_ticks;
  logic [15:0] compare;
  logic [2:0]  settle;
  logic [6:0]  percent_clamped;

  // item pipeline
  logic                s1_valid;
  fdssm_pkg::in_item_t s1_item;
  logic [32:0]         div10_mul;
  logic [32:0]         div100_mul;
  logic [32:0]         div1000_mul;
  logic                s2_valid;
  logic                s2_mode;
  logic                s2_over;
  logic [3:0]          s2_v_lo;
  logic [3:0]          s2_q1;
  logic [3:0]          s2_q2;
  logic [3:0]          s2_q3;
  logic                out_free;
  logic                s2_free;
  logic                s1_free;
  logic                s2_move;
  logic                in_accept;

  // display state
  logic [15:0]                       slot_counter;
  logic [15:0]                       slot_counter_next;
  logic [fdssm_pkg::DIGIT_IDX_W-1:0] current_digit;
  logic [fdssm_pkg::DIGIT_IDX_W-1:0] current_digit_next;
  logic [fdssm_pkg::DIGIT_IDX_W-1:0] digit_after;
  logic [3:0]                        digit_values      [fdssm_pkg::DIGIT_COUNT];
  logic [3:0]                        digit_values_next [fdssm_pkg::DIGIT_COUNT];
  logic                              digit_lit;
  logic                              digit_lit_next;
  logic [7:0]                        segment_latch;
  logic [7:0]                        segment_latch_next;
  logic [7:0]                        after_pattern;

  // low nibble of 10 * q
  function automatic logic [3:0] times10_lo(input logic [3:0] q);
    return {q[0], 3'b000} + {q[2:0], 1'b0};
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_length <= fdssm_pkg::SLOT_LENGTH_RST;
      brightness  <= fdssm_pkg::BRIGHTNESS_RST;
      dp_position <= fdssm_pkg::DP_POSITION_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fdssm_pkg::REG_SLOT_LENGTH: slot_length <= cfg_data;
        fdssm_pkg::REG_BRIGHTNESS:  brightness  <= cfg_data[6:0];
        fdssm_pkg::REG_DP_POSITION: dp_position <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (brightness > fdssm_pkg::BRIGHTNESS_MAX) begin
      percent_clamped = fdssm_pkg::BRIGHTNESS_MAX;
    end else if (brightness < fdssm_pkg::BRIGHTNESS_MIN) begin
      percent_clamped = fdssm_pkg::BRIGHTNESS_MIN;
    end else begin
      percent_clamped = brightness;
    end
  end

  // compare = (slot_length + 1) * percent / 100 - 1, all mod 2^16
  assign percent_mul = {24'd0, on_product} * {24'd0, fdssm_pkg::RECIP_PERCENT};

  always_ff @(posedge clk) begin
    slot_ticks <= {1'b0, slot_length} + 17'd1;
    percent    <= percent_clamped;
    on_product <= {7'd0, slot_ticks} * {17'd0, percent};
    on_ticks   <= percent_mul[fdssm_pkg::SHIFT_PERCENT +: 16];
    compare    <= on_ticks - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= fdssm_pkg::SETTLE_CYCLES;
    end else if (cfg_write) begin
      settle <= fdssm_pkg::SETTLE_CYCLES;
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  // handshake chain
  assign out_free  = !out_valid || !out_stall;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s2_move   = s2_valid && out_free;
  assign in_stall  = !s1_free || cfg_valid || (settle != 3'd0);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_item <= in_data;
    end
  end

  // quotients by 10, 100 and 1000 in parallel, only low nibbles kept
  assign div10_mul   = {17'd0, s1_item.value} * {16'd0, fdssm_pkg::RECIP_10};
  assign div100_mul  = {17'd0, s1_item.value} * {16'd0, fdssm_pkg::RECIP_100};
  assign div1000_mul = {17'd0, s1_item.value} * {16'd0, fdssm_pkg::RECIP_1000};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_mode <= s1_item.mode;
      s2_over <= s1_item.value > fdssm_pkg::VALUE_MAX;
      s2_v_lo <= s1_item.value[3:0];
      s2_q1   <= div10_mul[fdssm_pkg::SHIFT_10 +: 4];
      s2_q2   <= div100_mul[fdssm_pkg::SHIFT_100 +: 4];
      s2_q3   <= div1000_mul[fdssm_pkg::SHIFT_1000 +: 4];
    end
  end

  assign digit_after = current_digit + 1'b1;

  // decimal point sits on internal digit three minus the user position
  always_comb begin
    after_pattern = fdssm_pkg::seg_pattern(digit_values[digit_after]);
    if (digit_after == ~dp_position) begin
      after_pattern = after_pattern | fdssm_pkg::SEG_DP;
    end
  end

  always_comb begin
    slot_counter_next  = slot_counter;
    current_digit_next = current_digit;
    digit_lit_next     = digit_lit;
    segment_latch_next = segment_latch;
    for (int i = 0; i < fdssm_pkg::DIGIT_COUNT; i++) begin
      digit_values_next[i] = digit_values[i];
    end
    if (s2_move) begin
      if (s2_mode == fdssm_pkg::MODE_LOAD) begin
        if (s2_over) begin
          for (int i = 0; i < fdssm_pkg::DIGIT_COUNT; i++) begin
            digit_values_next[i] = fdssm_pkg::DIGIT_ERROR;
          end
        end else begin
          digit_values_next[0] = s2_v_lo - times10_lo(s2_q1);
          digit_values_next[1] = s2_q1 - times10_lo(s2_q2);
          digit_values_next[2] = s2_q2 - times10_lo(s2_q3);
          digit_values_next[3] = s2_q3;
        end
      end else begin
        // a counter above a lowered slot length also ends the slot
        if (slot_counter >= slot_length) begin
          slot_counter_next  = 16'd0;
          current_digit_next = digit_after;
          segment_latch_next = after_pattern;
          digit_lit_next     = 1'b1;
        end else begin
          slot_counter_next = slot_counter + 16'd1;
        end
        if (slot_counter_next == compare) begin
          digit_lit_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter  <= 16'd0;
      current_digit <= '0;
      digit_lit     <= 1'b1;
      segment_latch <= fdssm_pkg::SEG_RST;
      for (int i = 0; i < fdssm_pkg::DIGIT_COUNT; i++) begin
        digit_values[i] <= 4'd0;
      end
    end else begin
      slot_counter  <= slot_counter_next;
      current_digit <= current_digit_next;
      digit_lit     <= digit_lit_next;
      segment_latch <= segment_latch_next;
      for (int i = 0; i < fdssm_pkg::DIGIT_COUNT; i++) begin
        digit_values[i] <= digit_values_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_data.segments     <= segment_latch_next;
      out_data.digit_enable <= digit_lit_next ?
          (fdssm_pkg::DIGIT_COUNT'(1) << current_digit_next) : '0;
      out_data.active_index <= current_digit_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fdssm_checker.sv -----
// port-level checks for the seven-segment display driver, bound to the top level
// uses fdssm_pkg and the assertion macros header
`default_nettype none
`include "four_digit_seven_segment_mux_defines.svh"

module fdssm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire fdssm_pkg::in_item_t               in_data,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire fdssm_pkg::out_item_t              out_data,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [fdssm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [fdssm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic       enable_ok;
  logic [7:0] unused_ports;

  // enable is either dark or exactly the active digit
  assign enable_ok = (out_data.digit_enable == '0) ||
      (out_data.digit_enable == (fdssm_pkg::DIGIT_COUNT'(1) << out_data.active_index));
  assign unused_ports = {in_valid, in_data.mode, cfg_ready, cfg_index, cfg_data[2:0]};

  `FDSSM_ASSERT_SAME(a_enable_matches_index, out_valid, enable_ok, "digit enable not one-hot of active index")
  `FDSSM_ASSERT_SAME(a_no_item_during_cfg, cfg_valid, in_stall, "item accepted alongside a config write")
  `FDSSM_ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, in_stall, "input open right after a config write")
  `FDSSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind four_digit_seven_segment_mux fdssm_checker u_fdssm_checker (.*);

`default_nettype wire
